// ===== sv/ffha_pkg.sv =====
// Package for the first-fit heap allocator: request and result structs,
// status codes, default sizes and the step unit's flag group.
// No dependencies.
`timescale 1ns / 1ps

package ffha_pkg;

  // Default pool and header sizes in bytes.
  localparam int unsigned PoolBytesDef   = 4096;
  localparam int unsigned HeaderBytesDef = 4;

  // Fixed field widths of the request and result.
  localparam int unsigned ReqW = 13;
  localparam int unsigned OffW = 12;

  // Operation selected by the mode field.
  typedef enum logic {
    ModeAlloc = 1'b0,
    ModeFree  = 1'b1
  } mode_e;

  // Result status codes.
  typedef enum logic [2:0] {
    StatusOk       = 3'd0,
    StatusZero     = 3'd1,
    StatusLarge    = 3'd2,
    StatusNoFit    = 3'd3,
    StatusRange    = 3'd4,
    StatusFreed    = 3'd5,
    StatusNoStart  = 3'd6,
    StatusReserved = 3'd7
  } status_e;

  // One request.
  typedef struct packed {
    logic            mode;
    logic [ReqW-1:0] request_bytes;
    logic [OffW-1:0] payload_offset;
  } cmd_t;

  // One result.
  typedef struct packed {
    logic [OffW-1:0] granted_offset;
    status_e         status;
  } result_t;

  // Decisions of the step unit on the header under inspection.
  typedef struct packed {
    logic fit;        // free and large enough for the request
    logic split;      // remainder can hold a header plus one byte
    logic match;      // header sits at the block start being freed
    logic alloc_end;  // no room left for an allocation at this offset
    logic free_end;   // walk has reached the end of the pool
  } step_flags_t;

endpackage

// ===== sv/ffha_hdr_mem.sv =====
// Header store of the allocator: one entry per pool byte, one read port
// with registered data and one write port. Depends on nothing else.
// Entry 0 reads as the whole-pool free block until it is first written.
`timescale 1ns / 1ps

module ffha_hdr_mem #(
  parameter int unsigned POOL_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [$clog2(POOL_BYTES)-1:0] rd_addr_i,
  output logic [$clog2(POOL_BYTES):0]   rd_data_o,
  input  logic                          wr_en_i,
  input  logic [$clog2(POOL_BYTES)-1:0] wr_addr_i,
  input  logic [$clog2(POOL_BYTES):0]   wr_data_i
);

  localparam int unsigned AddrW = $clog2(POOL_BYTES);
  localparam int unsigned EntW  = AddrW + 1;
  localparam logic [EntW-1:0] ResetEntry = EntW'(POOL_BYTES - HEADER_BYTES);

  logic [EntW-1:0] mem_q [POOL_BYTES];
  logic [EntW-1:0] rd_data_q;
  logic            zero_written_q;
  logic            use_reset_q;

  // Storage array: synchronous write, registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bit for entry 0, the only entry the walk reads before writing it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_written_q <= 1'b0;
      use_reset_q    <= 1'b0;
    end else begin
      if (wr_en_i && (wr_addr_i == '0)) begin
        zero_written_q <= 1'b1;
      end
      if (rd_en_i) begin
        use_reset_q <= (rd_addr_i == '0) && !zero_written_q;
      end
    end
  end

  assign rd_data_o = use_reset_q ? ResetEntry : rd_data_q;

endmodule

// ===== sv/ffha_step_unit.sv =====
// Shared step unit: the adders and comparators applied to one header per
// cycle during a walk. Depends on ffha_pkg.
`timescale 1ns / 1ps

module ffha_step_unit #(
  parameter int unsigned POOL_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic [$clog2(POOL_BYTES):0]   pos_i,
  input  logic [$clog2(POOL_BYTES)-1:0] size_i,
  input  logic                          used_i,
  input  logic [$clog2(POOL_BYTES)-1:0] req_i,
  input  logic [$clog2(POOL_BYTES):0]   start_pos_i,
  output logic [$clog2(POOL_BYTES):0]   next_pos_o,
  output logic [$clog2(POOL_BYTES):0]   split_pos_o,
  output logic [$clog2(POOL_BYTES)-1:0] remainder_o,
  output ffha_pkg::step_flags_t         flags_o
);

  localparam int unsigned SzW  = $clog2(POOL_BYTES);
  localparam int unsigned PosW = SzW + 1;
  localparam logic [PosW-1:0] Hdr      = PosW'(HEADER_BYTES);
  localparam logic [PosW-1:0] AllocLim = PosW'(POOL_BYTES - HEADER_BYTES);
  localparam logic [PosW-1:0] PoolEnd  = PosW'(POOL_BYTES);

  logic [PosW-1:0] size_w;
  logic [PosW-1:0] req_w;

  assign size_w = PosW'(size_i);
  assign req_w  = PosW'(req_i);

  // Next header in the chain and the header offset of a split remainder.
  assign next_pos_o  = pos_i + size_w + Hdr;
  assign split_pos_o = pos_i + Hdr + req_w;
  assign remainder_o = size_i - req_i - SzW'(HEADER_BYTES);

  // Decisions on the current header.
  always_comb begin
    flags_o.fit       = (size_i >= req_i) && !used_i;
    flags_o.split     = size_w >= (req_w + Hdr + PosW'(1));
    flags_o.match     = pos_i == start_pos_i;
    flags_o.alloc_end = pos_i >= AllocLim;
    flags_o.free_end  = pos_i >= PoolEnd;
  end

endmodule

// ===== sv/first_fit_heap_allocator.sv =====
// First-fit heap allocator with in-pool block headers.
// Rejected requests (zero, too large, out of range) give their result without a
// walk; otherwise the walk reads one header per cycle from the header store port,
// and a granted allocation then passes through a mark state. One request at a time.
// Reset: the pool is one free block at offset 0, with no clearing pass.
// Results are a one-cycle strobe that the receiver cannot stall.
`timescale 1ns / 1ps

module first_fit_heap_allocator #(
  parameter int unsigned POOL_BYTES   = ffha_pkg::PoolBytesDef,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HeaderBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ffha_pkg::cmd_t    cmd_i,
  output logic              result_valid_o,
  output ffha_pkg::result_t result_o
);

  localparam int unsigned AddrW = $clog2(POOL_BYTES);
  localparam int unsigned SzW   = AddrW;
  localparam int unsigned PosW  = AddrW + 1;
  localparam int unsigned EntW  = SzW + 1;
  localparam int unsigned WideW = (PosW > ffha_pkg::ReqW) ? PosW : ffha_pkg::ReqW;
  localparam logic [WideW-1:0] ReqLimit = WideW'(POOL_BYTES - HEADER_BYTES);
  localparam logic [WideW-1:0] OffHigh  = WideW'(POOL_BYTES - 1);
  localparam logic [WideW-1:0] HdrWide  = WideW'(HEADER_BYTES);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StWalk = 3'b010,
    StMark = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic                  mode_q, mode_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [SzW-1:0]        req_q, req_d;
  logic [PosW-1:0]       start_pos_q, start_pos_d;
  logic [SzW-1:0]        size_q, size_d;
  logic                  split_q, split_d;
  logic                  res_valid_q, res_valid_d;
  ffha_pkg::result_t     result_q, result_d;

  logic                  rd_en;
  logic [AddrW-1:0]      rd_addr;
  logic [EntW-1:0]       rd_data;
  logic                  wr_en;
  logic [AddrW-1:0]      wr_addr;
  logic [EntW-1:0]       wr_data;

  logic [SzW-1:0]        cur_size;
  logic                  cur_used;
  logic [PosW-1:0]       next_pos;
  logic [PosW-1:0]       split_pos;
  logic [SzW-1:0]        remainder;
  ffha_pkg::step_flags_t flags;

  logic [WideW-1:0]      req_wide;
  logic [WideW-1:0]      off_wide;
  logic [WideW-1:0]      grant_wide;

  // Header store.
  ffha_hdr_mem #(
    .POOL_BYTES  (POOL_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_hdr_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  assign cur_size = rd_data[SzW-1:0];
  assign cur_used = rd_data[SzW];

  // Shared step unit for the header just read.
  ffha_step_unit #(
    .POOL_BYTES  (POOL_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_step (
    .pos_i      (pos_q),
    .size_i     (cur_size),
    .used_i     (cur_used),
    .req_i      (req_q),
    .start_pos_i(start_pos_q),
    .next_pos_o (next_pos),
    .split_pos_o(split_pos),
    .remainder_o(remainder),
    .flags_o    (flags)
  );

  assign req_wide   = WideW'(cmd_i.request_bytes);
  assign off_wide   = WideW'(cmd_i.payload_offset);
  assign grant_wide = WideW'(pos_q) + HdrWide;

  // Sequencer: request checks, header walk and header updates.
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    pos_d       = pos_q;
    req_d       = req_q;
    start_pos_d = start_pos_q;
    size_d      = size_q;
    split_d     = split_q;
    res_valid_d = 1'b0;
    result_d    = result_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = pos_q[AddrW-1:0];
    wr_data     = '0;

    unique case (state_q)
      StIdle: begin
        if (start) begin
          result_d.granted_offset = '0;
          mode_d                  = cmd_i.mode;
          pos_d                   = '0;
          if (cmd_i.mode == ffha_pkg::ModeAlloc) begin
            if (cmd_i.request_bytes == '0) begin
              res_valid_d     = 1'b1;
              result_d.status = ffha_pkg::StatusZero;
            end else if (req_wide > ReqLimit) begin
              res_valid_d     = 1'b1;
              result_d.status = ffha_pkg::StatusLarge;
            end else begin
              req_d   = req_wide[SzW-1:0];
              rd_en   = 1'b1;
              state_d = StWalk;
            end
          end else begin
            if ((off_wide < HdrWide) || (off_wide > OffHigh)) begin
              res_valid_d     = 1'b1;
              result_d.status = ffha_pkg::StatusRange;
            end else begin
              start_pos_d = PosW'(off_wide - HdrWide);
              rd_en       = 1'b1;
              state_d     = StWalk;
            end
          end
        end
      end

      StWalk: begin
        if (mode_q == ffha_pkg::ModeAlloc) begin
          if (flags.alloc_end) begin
            res_valid_d     = 1'b1;
            result_d.status = ffha_pkg::StatusNoFit;
            state_d         = StIdle;
          end else if (flags.fit) begin
            // Claim this block; a large remainder gets a free header of its own.
            size_d  = cur_size;
            split_d = flags.split;
            if (flags.split) begin
              wr_en   = 1'b1;
              wr_addr = split_pos[AddrW-1:0];
              wr_data = {1'b0, remainder};
            end
            state_d = StMark;
          end else begin
            pos_d   = next_pos;
            rd_en   = 1'b1;
            rd_addr = next_pos[AddrW-1:0];
          end
        end else begin
          if (flags.free_end) begin
            res_valid_d     = 1'b1;
            result_d.status = ffha_pkg::StatusNoStart;
            state_d         = StIdle;
          end else if (flags.match) begin
            // Clear the in-use flag, or report a double release.
            res_valid_d = 1'b1;
            if (cur_used) begin
              wr_en           = 1'b1;
              wr_data         = {1'b0, cur_size};
              result_d.status = ffha_pkg::StatusOk;
            end else begin
              result_d.status = ffha_pkg::StatusFreed;
            end
            state_d = StIdle;
          end else begin
            pos_d   = next_pos;
            rd_en   = 1'b1;
            rd_addr = next_pos[AddrW-1:0];
          end
        end
      end

      StMark: begin
        // Mark the granted block in use and return its payload offset.
        wr_en                   = 1'b1;
        wr_data                 = {1'b1, split_q ? req_q : size_q};
        res_valid_d             = 1'b1;
        result_d.granted_offset = grant_wide[ffha_pkg::OffW-1:0];
        result_d.status         = ffha_pkg::StatusOk;
        state_d                 = StIdle;
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    pos_q       <= pos_d;
    req_q       <= req_d;
    start_pos_q <= start_pos_d;
    size_q      <= size_d;
    split_q     <= split_d;
    result_q    <= result_d;
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = res_valid_q;
  assign result_o       = result_q;

endmodule

// ===== tb/tb_first_fit_heap_allocator.sv =====
// Self-checking testbench for the first-fit heap allocator: a directed table,
// then random allocate and free requests, checked against typed table results or a header-chain predictor.
// Depends on ffha_pkg and first_fit_heap_allocator.
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;

  localparam int unsigned PoolB   = ffha_pkg::PoolBytesDef;
  localparam int unsigned HdrB    = ffha_pkg::HeaderBytesDef;
  localparam int unsigned LimitB  = PoolB - HdrB;
  localparam int unsigned RandReq = 555;
  localparam int unsigned Drain   = PoolB / HdrB + 8;
  localparam int unsigned CmdW    = $bits(ffha_pkg::cmd_t);

  // One row of the directed table.
  typedef struct {
    ffha_pkg::cmd_t    c;
    bit                typed;
    ffha_pkg::result_t r;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_n = 1'b0;
  logic              req_start = 1'b0;
  ffha_pkg::cmd_t    req_cmd = '0;
  logic              busy;
  logic              res_strobe;
  ffha_pkg::result_t res_data;

  // Predictor state: one header word per pool offset, in-use flag in bit 17.
  logic [17:0] pool_hdr [PoolB];

  ffha_pkg::result_t awaited_grants[$];
  logic [11:0]       live_offs[$];
  logic [11:0]       freed_offs[$];
  dir_row_t          dir_tab[$];
  int unsigned       mismatches = 0;
  bit                burst = 1'b0;

  first_fit_heap_allocator #(
    .POOL_BYTES  (PoolB),
    .HEADER_BYTES(HdrB)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .start         (req_start),
    .busy          (busy),
    .cmd_i         (req_cmd),
    .result_valid_o(res_strobe),
    .result_o      (res_data)
  );

  // Clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog against a hung walk or a lost result.
  initial begin
    #(64'd20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // Walks the header chain the way the allocator does and updates the headers.
  task automatic compute_grant(input ffha_pkg::cmd_t c, output ffha_pkg::result_t r);
    int unsigned pos;
    int unsigned sz;
    int unsigned req;
    int unsigned off;
    int unsigned blk_pos;
    int unsigned nxt;
    bit found;
    r.granted_offset = '0;
    r.status = ffha_pkg::StatusOk;
    pos = 0;
    found = 1'b0;
    if (c.mode == ffha_pkg::ModeAlloc) begin
      req = 32'(c.request_bytes);
      if (req == 0) begin
        r.status = ffha_pkg::StatusZero;
      end else if (req > LimitB) begin
        r.status = ffha_pkg::StatusLarge;
      end else begin
        sz = 0;
        while (!found && pos <= LimitB - 1) begin
          sz = 32'(pool_hdr[pos][16:0]);
          if (sz >= req && !pool_hdr[pos][17]) found = 1'b1;
          else pos += sz + HdrB;
        end
        if (!found) begin
          r.status = ffha_pkg::StatusNoFit;
        end else begin
          // Split off the tail when it can hold a header and one byte.
          if (sz >= req + HdrB + 1) begin
            nxt = pos + HdrB + req;
            if (nxt < PoolB) pool_hdr[nxt] = {1'b0, 17'(sz - req - HdrB)};
            sz = req;
          end
          pool_hdr[pos] = {1'b1, 17'(sz)};
          r.granted_offset = 12'(pos + HdrB);
        end
      end
    end else begin
      off = 32'(c.payload_offset);
      if (off < HdrB || off > PoolB - 1) begin
        r.status = ffha_pkg::StatusRange;
      end else begin
        blk_pos = off - HdrB;
        while (!found && pos < PoolB) begin
          if (pos == blk_pos) found = 1'b1;
          else pos += 32'(pool_hdr[pos][16:0]) + HdrB;
        end
        if (!found) begin
          r.status = ffha_pkg::StatusNoStart;
        end else if (pool_hdr[pos][17]) begin
          pool_hdr[pos][17] = 1'b0;
        end else begin
          r.status = ffha_pkg::StatusFreed;
        end
      end
    end
  endtask

  task automatic add_row(input logic m, input int unsigned nbytes, input int unsigned off,
                         input bit typed, input int unsigned g,
                         input ffha_pkg::status_e st);
    dir_row_t row;
    row.c.mode           = m;
    row.c.request_bytes  = 13'(nbytes);
    row.c.payload_offset = 12'(off);
    row.typed            = typed;
    row.r.granted_offset = 12'(g);
    row.r.status         = st;
    dir_tab.push_back(row);
  endtask

  // Presents one request and records its expected result once it is taken.
  task automatic send_request(input ffha_pkg::cmd_t c, input bit typed,
                              input ffha_pkg::result_t typed_res);
    int unsigned gap;
    ffha_pkg::result_t pred;
    int i;
    gap = burst ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap != 0) begin
      req_start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_start <= 1'b1;
    req_cmd   <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    compute_grant(c, pred);
    awaited_grants.push_back(typed ? typed_res : pred);
    // Track live and released payloads for well-formed frees later on.
    if (pred.status == ffha_pkg::StatusOk) begin
      if (c.mode == ffha_pkg::ModeAlloc) begin
        live_offs.push_back(pred.granted_offset);
      end else begin
        for (i = 0; i < live_offs.size(); i++) begin
          if (live_offs[i] == c.payload_offset) begin
            live_offs.delete(i);
            break;
          end
        end
        freed_offs.push_back(c.payload_offset);
        if (freed_offs.size() > 64) void'(freed_offs.pop_front());
      end
    end
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    ffha_pkg::result_t want;
    if (rst_n && res_strobe) begin
      if (awaited_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: offset %0d status %0d",
                   res_data.granted_offset, res_data.status);
      end else begin
        want = awaited_grants.pop_front();
        if (res_data.granted_offset !== want.granted_offset ||
            res_data.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: offset exp %0d got %0d, status exp %0d got %0d",
                     want.granted_offset, res_data.granted_offset,
                     want.status, res_data.status);
        end
      end
    end
  end

  // Main sequence.
  initial begin
    ffha_pkg::cmd_t    c;
    ffha_pkg::result_t none;
    int unsigned pick;
    int unsigned sel;
    int n;
    none = '0;
    foreach (pool_hdr[k]) pool_hdr[k] = '0;
    pool_hdr[0] = {1'b0, 17'(LimitB)};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // Directed part: size and range edges, then a short split and reuse story.
    add_row(ffha_pkg::ModeAlloc, 0,    0,    1, 0, ffha_pkg::StatusZero);
    add_row(ffha_pkg::ModeAlloc, 4093, 0,    1, 0, ffha_pkg::StatusLarge);
    add_row(ffha_pkg::ModeAlloc, 8191, 4095, 1, 0, ffha_pkg::StatusLarge);
    add_row(ffha_pkg::ModeFree,  8191, 0,    1, 0, ffha_pkg::StatusRange);
    add_row(ffha_pkg::ModeFree,  0,    3,    1, 0, ffha_pkg::StatusRange);
    add_row(ffha_pkg::ModeFree,  0,    4,    1, 0, ffha_pkg::StatusFreed);
    add_row(ffha_pkg::ModeFree,  0,    4095, 1, 0, ffha_pkg::StatusNoStart);
    add_row(ffha_pkg::ModeAlloc, 4092, 0,    1, 4, ffha_pkg::StatusOk);
    add_row(ffha_pkg::ModeAlloc, 1,    0,    1, 0, ffha_pkg::StatusNoFit);
    add_row(ffha_pkg::ModeFree,  0,    4095, 0, 0, ffha_pkg::StatusOk);
    add_row(ffha_pkg::ModeFree,  0,    4,    1, 0, ffha_pkg::StatusOk);
    add_row(ffha_pkg::ModeFree,  0,    4,    1, 0, ffha_pkg::StatusFreed);
    add_row(ffha_pkg::ModeAlloc, 1,    0,    0, 0, ffha_pkg::StatusOk);
    add_row(ffha_pkg::ModeFree,  0,    6,    0, 0, ffha_pkg::StatusOk);
    add_row(ffha_pkg::ModeAlloc, 10,   0,    0, 0, ffha_pkg::StatusOk);
    add_row(ffha_pkg::ModeAlloc, 4068, 0,    0, 0, ffha_pkg::StatusOk);
    add_row(ffha_pkg::ModeAlloc, 2,    0,    0, 0, ffha_pkg::StatusOk);
    add_row(ffha_pkg::ModeAlloc, 1,    0,    0, 0, ffha_pkg::StatusOk);
    add_row(ffha_pkg::ModeFree,  0,    4095, 0, 0, ffha_pkg::StatusOk);
    add_row(ffha_pkg::ModeFree,  0,    23,   0, 0, ffha_pkg::StatusOk);
    add_row(ffha_pkg::ModeAlloc, 4069, 0,    0, 0, ffha_pkg::StatusOk);
    add_row(ffha_pkg::ModeAlloc, 4064, 0,    0, 0, ffha_pkg::StatusOk);
    add_row(ffha_pkg::ModeFree,  0,    9,    0, 0, ffha_pkg::StatusOk);
    add_row(ffha_pkg::ModeAlloc, 6,    0,    0, 0, ffha_pkg::StatusOk);
    add_row(ffha_pkg::ModeAlloc, 4096, 0,    1, 0, ffha_pkg::StatusLarge);
    foreach (dir_tab[k]) send_request(dir_tab[k].c, dir_tab[k].typed, dir_tab[k].r);

    // Random part: mostly small allocations and frees of live payloads.
    for (n = 0; n < RandReq; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      c = ffha_pkg::cmd_t'(CmdW'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        c.mode = ffha_pkg::ModeAlloc;
        sel = $urandom_range(0, 99);
        if (sel < 70)      c.request_bytes = 13'($urandom_range(1, 48));
        else if (sel < 85) c.request_bytes = 13'($urandom_range(49, 600));
        else if (sel < 93) c.request_bytes = 13'($urandom_range(601, 4096));
        else if (sel < 97) c.request_bytes = '0;
        else               c.request_bytes = 13'($urandom_range(4097, 8191));
      end else begin
        c.mode = ffha_pkg::ModeFree;
        sel = $urandom_range(0, 99);
        if (sel < 65 && live_offs.size() != 0)
          c.payload_offset = live_offs[$urandom_range(0, live_offs.size() - 1)];
        else if (sel < 80 && freed_offs.size() != 0)
          c.payload_offset = freed_offs[$urandom_range(0, freed_offs.size() - 1)];
        else if (sel < 92)
          c.payload_offset = 12'($urandom_range(0, 4095));
        else
          c.payload_offset = 12'($urandom_range(0, 7));
      end
      send_request(c, 1'b0, none);
    end

    // Drain and finish.
    @(negedge clk_i);
    req_start <= 1'b0;
    while (awaited_grants.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    if (mismatches == 0 && awaited_grants.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
